[hdl/lbp_3x3_code_stream_assert.svh]
// ----------------------------------------------------------------------------
// LBP assertion macros
// Shared property forms for the LBP code stream; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef LBP_3X3_CODE_STREAM_ASSERT_SVH
`define LBP_3X3_CODE_STREAM_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LBP assertion failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define LBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LBP assertion failed one cycle later");

`endif

[hdl/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// LBP package
// Sizes, types and register codes shared by the LBP code stream modules.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int PIXEL_BITS     = 8;
    localparam int MIN_DIM        = 3;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 12;
    localparam int PIXEL_PORT     = 8;
    localparam int CODE_BITS      = 8;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 12;
    localparam int OUT_DEPTH      = 3;
    localparam int LEVEL_BITS     = $clog2(OUT_DEPTH + 1);
    localparam int PTR_BITS       = $clog2(OUT_DEPTH);

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    // code bit positions
    localparam int BIT_TOP_LEFT  = 7;
    localparam int BIT_TOP       = 6;
    localparam int BIT_TOP_RIGHT = 5;
    localparam int BIT_RIGHT     = 4;
    localparam int BIT_BOT_RIGHT = 3;
    localparam int BIT_BOTTOM    = 2;
    localparam int BIT_BOT_LEFT  = 1;
    localparam int BIT_LEFT      = 0;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [HEIGHT_BITS-1:0] row_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0),
        REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1)
    } cfg_reg_t;

    // control carried with a pixel into the window stage
    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
        col_t col;
    } lbp_ctl_t;

    // one result word
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 row_end;
        logic                 frame_end;
    } lbp_word_t;

endpackage

[hdl/lbp_3x3_code_stream.sv]
// ----------------------------------------------------------------------------
// LBP 3x3 code stream
// Raster pixel stream in, one 8-bit local binary pattern code per interior
// pixel out, with row-end and frame-end marks.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid/in_ready/pixel. Codes leave on
//   out_valid/out_ready with lbp_code, row_end and frame_end; a frame of H
//   rows of W pixels gives (H-2)x(W-2) words. Border pixels give none.
//   Registers image_width (index 0) and image_height (index 1) are written on
//   cfg_valid/cfg_ready (always ready); write them only while the block is idle
//   (the block does not enforce this). A write also restarts the frame at row 0, column 0.
//   Throughput: one pixel per clock while in_ready is high. The code of a pixel
//   is formed from the registered line-store read and the registered pixel,
//   then written into the output queue, from which it is presented.
//   A three-word output queue absorbs results; when the receiver stalls,
//   in_ready drops once the queue and the window stage could fill it.
//   Reset clears counters, window and queue and sets 640x480; line memories
//   are not cleared, since each row is rewritten before it is used.
// ----------------------------------------------------------------------------
module lbp_3x3_code_stream
    import lbp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIXEL_PORT-1:0]     pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CODE_BITS-1:0]      lbp_code,
    output logic                      row_end,
    output logic                      frame_end,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    `include "lbp_3x3_code_stream_assert.svh"

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [WIDTH_BITS-1:0]  width_next;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [HEIGHT_BITS-1:0] height_next;
    col_t                   col_reg;
    col_t                   col_next;
    row_t                   row_reg;
    row_t                   row_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    lbp_ctl_t               s1_ctl_reg;
    lbp_ctl_t               s1_ctl_next;
    pix_t                   s1_pixel_reg;
    col_t                   w_last;
    row_t                   h_last;
    logic                   in_acc;
    logic                   cfg_acc;
    logic                   cfg_hit;
    pix_t                   rd_older;
    pix_t                   rd_newer;
    logic                   push;
    lbp_word_t              push_word;
    lbp_word_t              out_word;
    logic [LEVEL_BITS-1:0]  level;
    logic [LEVEL_BITS:0]    pending;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_acc && ((cfg_index == REG_IMAGE_WIDTH) ||
                                   (cfg_index == REG_IMAGE_HEIGHT));

    // hold input while queued plus in-flight words could overfill the queue
    assign pending  = {1'b0, level} + (LEVEL_BITS + 1)'(s1_valid_reg);
    assign in_ready = (pending < (LEVEL_BITS + 1)'(OUT_DEPTH));
    assign in_acc   = in_valid && in_ready;

    // clamp frame size to the supported range
    always_comb
    begin
        if (int'(width_reg) < MIN_DIM)
        begin
            w_last = COL_BITS'(MIN_DIM - 1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_last = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = COL_BITS'(width_reg - 1'b1);
        end

        if (int'(height_reg) < MIN_DIM)
        begin
            h_last = HEIGHT_BITS'(MIN_DIM - 1);
        end
        else
        begin
            h_last = height_reg - 1'b1;
        end
    end

    // configuration registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_acc && (cfg_index == REG_IMAGE_WIDTH))
        begin
            width_next = cfg_data[WIDTH_BITS-1:0];
        end
        if (cfg_acc && (cfg_index == REG_IMAGE_HEIGHT))
        begin
            height_next = cfg_data[HEIGHT_BITS-1:0];
        end
    end

    // advance raster position; restart the frame on a register write
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // tag the pixel for the window stage
    always_comb
    begin
        s1_valid_next         = in_acc;
        s1_ctl_next.emit      = (col_reg >= COL_BITS'(2)) && (row_reg >= HEIGHT_BITS'(2));
        s1_ctl_next.row_end   = (col_reg == w_last);
        s1_ctl_next.frame_end = (col_reg == w_last) && (row_reg == h_last);
        s1_ctl_next.col       = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // pixel payload and its tag
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ctl_reg   <= s1_ctl_next;
            s1_pixel_reg <= pixel[PIXEL_BITS-1:0];
        end
    end

    lbp_line_store u_line_store (
        .clk      (clk),
        .rd_en    (in_acc),
        .rd_addr  (col_reg),
        .wr_en    (s1_valid_reg),
        .wr_addr  (s1_ctl_reg.col),
        .wr_older (rd_newer),
        .wr_newer (s1_pixel_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer)
    );

    lbp_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1_ctl   (s1_ctl_reg),
        .bot      (s1_pixel_reg),
        .top      (rd_older),
        .mid      (rd_newer),
        .push     (push),
        .word     (push_word)
    );

    lbp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word),
        .level     (level)
    );

    assign lbp_code  = out_word.code;
    assign row_end   = out_word.row_end;
    assign frame_end = out_word.frame_end;

    `LBP_ASSERT_NEXT(a_accept_to_window, in_acc, s1_valid_reg)
    `LBP_ASSERT_SAME(a_frame_end_row_end, out_valid && frame_end, row_end)
    `LBP_ASSERT_NEXT(a_row_wrap, in_acc && !cfg_hit && (col_reg == w_last), col_reg == '0)

endmodule

[hdl/lbp_line_store.sv]
// ----------------------------------------------------------------------------
// LBP line store
// Two row memories sharing one address; synchronous read into output registers.
// ----------------------------------------------------------------------------
module lbp_line_store
    import lbp_pkg::*;
(
    input  logic clk,
    input  logic rd_en,
    input  col_t rd_addr,
    input  logic wr_en,
    input  col_t wr_addr,
    input  pix_t wr_older,
    input  pix_t wr_newer,
    output pix_t rd_older,
    output pix_t rd_newer
);

    pix_t older_mem [MAX_WIDTH];
    pix_t newer_mem [MAX_WIDTH];
    pix_t older_reg;
    pix_t newer_reg;

    // write back the shifted column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    // register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            older_reg <= older_mem[rd_addr];
            newer_reg <= newer_mem[rd_addr];
        end
    end

    assign rd_older = older_reg;
    assign rd_newer = newer_reg;

endmodule

[hdl/lbp_window.sv]
// ----------------------------------------------------------------------------
// LBP window stage
// Holds two window columns, forms the 8-bit code and shifts the window.
// ----------------------------------------------------------------------------
module lbp_window
    import lbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s1_valid,
    input  lbp_ctl_t  s1_ctl,
    input  pix_t      bot,
    input  pix_t      top,
    input  pix_t      mid,
    output logic      push,
    output lbp_word_t word
);

    // [0..2] top/mid/bottom of column c-2, [3..5] of column c-1
    pix_t win_reg  [6];
    pix_t win_next [6];
    pix_t centre;
    logic [CODE_BITS-1:0] code;

    assign centre = win_reg[4];

    // compare each neighbor against the center
    always_comb
    begin
        code = '0;
        code[BIT_TOP_LEFT]  = (win_reg[0] >= centre);
        code[BIT_TOP]       = (win_reg[3] >= centre);
        code[BIT_TOP_RIGHT] = (top >= centre);
        code[BIT_RIGHT]     = (mid >= centre);
        code[BIT_BOT_RIGHT] = (bot >= centre);
        code[BIT_BOTTOM]    = (win_reg[5] >= centre);
        code[BIT_BOT_LEFT]  = (win_reg[2] >= centre);
        code[BIT_LEFT]      = (win_reg[1] >= centre);
    end

    assign push           = s1_valid && s1_ctl.emit;
    assign word.code      = code;
    assign word.row_end   = s1_ctl.row_end;
    assign word.frame_end = s1_ctl.frame_end;

    // shift the window by one column
    always_comb
    begin
        win_next = win_reg;
        if (s1_valid)
        begin
            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = top;
            win_next[4] = mid;
            win_next[5] = bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

[hdl/lbp_out_fifo.sv]
// ----------------------------------------------------------------------------
// LBP output queue
// Small register queue that decouples result words from the receiver.
// ----------------------------------------------------------------------------
module lbp_out_fifo
    import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lbp_word_t             push_word,
    input  logic                  out_ready,
    output logic                  out_valid,
    output lbp_word_t             out_word,
    output logic [LEVEL_BITS-1:0] level
);

    `include "lbp_3x3_code_stream_assert.svh"

    lbp_word_t             slot_reg [OUT_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [LEVEL_BITS-1:0] level_reg;
    logic [LEVEL_BITS-1:0] level_next;
    logic                  pop;

    assign out_valid = (level_reg != '0);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid && out_ready;

    // advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(OUT_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(OUT_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    `LBP_ASSERT_SAME(a_no_overflow, push, level_reg != LEVEL_BITS'(OUT_DEPTH))
    `LBP_ASSERT_NEXT(a_fill_up, push && !pop, level_reg == $past(level_reg) + 1'b1)
    `LBP_ASSERT_NEXT(a_drain, !push && pop, level_reg == $past(level_reg) - 1'b1)

endmodule
